[rtl/core/hse_pkg.sv]
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine package
// Transfer types, action codes, pad bytes and the SHA-256 constants and
// round functions shared by the engine, its memories and its checker.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int WORD_W    = 32;
  localparam int BLK_WORDS = 16;
  localparam int LEN_W     = 64;

  localparam logic [1:0] ACT_KEY_BYTE = 2'd0;
  localparam logic [1:0] ACT_KEY_END  = 2'd1;
  localparam logic [1:0] ACT_MSG_BYTE = 2'd2;
  localparam logic [1:0] ACT_MSG_END  = 2'd3;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] tag_word;
    logic        last_word;
  } out_t;

  function automatic logic [31:0] h_init(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] k_round(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/core/hse_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hse_ram #(
  parameter int WIDTH = hse_pkg::WORD_W,
  parameter int DEPTH = hse_pkg::BLK_WORDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/hmac_sha256_engine.sv]
// A key or message byte that completes a 64-byte block starts a compression, whose
// rounds each pass through S_R0 and S_R1 on the block RAM. The 65th key byte first
// compresses the first 64 key bytes. Ending the key loads the padded key into the block
// RAM plus one compression; a long key first needs one or two more compressions and a
// digest copy. Ending the message costs three or four compressions before the tag, which
// leaves as four words. Reset is synchronous; all control state clears, no memory sweep.
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine
// Streams key and message bytes, keeps the block schedule and the key in
// small RAMs, and returns the 32-byte tag as four big-endian words.
// ----------------------------------------------------------------------------
module hmac_sha256_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hse_pkg::out_t out_data
);
  import hse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_KLOAD, S_CSTART, S_R0, S_R1, S_RLAST, S_CADD,
    S_FPAD, S_FZERO, S_KDIG, S_OLOAD, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    J_BLOCK, J_IPAD, J_PAD2, J_KEYDIG, J_INNER, J_OPAD, J_TAG
  } job_t;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt, fin_job_r, fin_job_nxt;

  logic [4:0]       idx_r, idx_nxt;
  logic [7:0]       pad_r, pad_nxt;
  logic [23:0]      acc_r, acc_nxt;
  logic [LEN_W-1:0] klen_r, klen_nxt, mlen_r, mlen_nxt;
  logic             phase_r, phase_nxt;
  logic [15:0]      kval_r, kval_nxt;
  logic [31:0]      chain_r [8];
  logic [31:0]      chain_nxt [8];
  logic [31:0]      v_r [8];
  logic [31:0]      v_nxt [8];
  logic [31:0]      inner_r [8];
  logic [31:0]      inner_nxt [8];
  logic [5:0]       t_r, t_nxt;
  logic             pend_r, pend_nxt;
  logic [31:0]      w16_r, w16_nxt, w15_r, w15_nxt, w_r, w_nxt, k_r, k_nxt;
  logic [5:0]       fpos_r, fpos_nxt;
  logic [63:0]      fbits_r, fbits_nxt;
  logic             lenhere_r, lenhere_nxt;
  logic             oval_r, oval_nxt;
  logic [63:0]      oword_r, oword_nxt;
  logic             olast_r, olast_nxt;
  logic [1:0]       ek_r, ek_nxt;

  logic        w_we;
  logic [3:0]  w_waddr, w_ra, w_rb;
  logic [31:0] w_wdata, w_qa, w_qb;
  logic        k_we;
  logic [3:0]  k_waddr, k_ra;
  logic [31:0] k_wdata, k_q;

  logic [31:0] rnd [8];
  logic [31:0] sum [8];
  logic [31:0] t1, t2, ch, mj, w_calc, pad_word, part_word;
  logic [3:0]  kprev;
  logic [63:0] total;

  hse_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_wram_a (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_ra), .rdata(w_qa)
  );
  hse_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_wram_b (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_rb), .rdata(w_qb)
  );
  hse_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_kram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_ra), .rdata(k_q)
  );

  always_comb begin
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + big_sig1(v_r[4]) + ch + k_r + w_r;
    t2 = big_sig0(v_r[0]) + mj;
    rnd[0] = t1 + t2;
    rnd[1] = v_r[0];
    rnd[2] = v_r[1];
    rnd[3] = v_r[2];
    rnd[4] = v_r[3] + t1;
    rnd[5] = v_r[4];
    rnd[6] = v_r[5];
    rnd[7] = v_r[6];
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain_r[i] + v_r[i];
    end
    w_calc = (t_r < 6'd16) ? w16_r : w16_r + sml_sig0(w15_r) + w_qa + sml_sig1(w_qb);
    unique case (fpos_r[1:0])
      2'd0: pad_word = 32'h8000_0000;
      2'd1: pad_word = {acc_r[7:0], 8'h80, 16'h0};
      2'd2: pad_word = {acc_r[15:0], 8'h80, 8'h0};
      2'd3: pad_word = {acc_r[23:0], 8'h80};
    endcase
    unique case (klen_r[1:0])
      2'd0: part_word = 32'h0;
      2'd1: part_word = {acc_r[7:0], 24'h0};
      2'd2: part_word = {acc_r[15:0], 16'h0};
      2'd3: part_word = {acc_r[23:0], 8'h0};
    endcase
    kprev = idx_r[3:0] - 4'd1;
    total = mlen_r + 64'd64;
  end

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    fin_job_nxt = fin_job_r;
    idx_nxt     = idx_r;
    pad_nxt     = pad_r;
    acc_nxt     = acc_r;
    klen_nxt    = klen_r;
    mlen_nxt    = mlen_r;
    phase_nxt   = phase_r;
    kval_nxt    = kval_r;
    chain_nxt   = chain_r;
    v_nxt       = v_r;
    inner_nxt   = inner_r;
    t_nxt       = t_r;
    pend_nxt    = pend_r;
    w16_nxt     = w16_r;
    w15_nxt     = w15_r;
    w_nxt       = w_r;
    k_nxt       = k_r;
    fpos_nxt    = fpos_r;
    fbits_nxt   = fbits_r;
    lenhere_nxt = lenhere_r;
    oval_nxt    = oval_r;
    oword_nxt   = oword_r;
    olast_nxt   = olast_r;
    ek_nxt      = ek_r;
    w_we        = 1'b0;
    w_waddr     = 4'd0;
    w_wdata     = 32'h0;
    w_ra        = 4'd0;
    w_rb        = 4'd0;
    k_we        = 1'b0;
    k_waddr     = 4'd0;
    k_wdata     = 32'h0;
    k_ra        = idx_r[3:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!phase_r) begin
            if (in_data.action == ACT_KEY_BYTE) begin
              acc_nxt  = {acc_r[15:0], in_data.data_byte};
              klen_nxt = klen_r + 64'd1;
              if (klen_r[63:6] == 58'd0) begin
                if (klen_r[1:0] == 2'd3) begin
                  k_we                  = 1'b1;
                  k_waddr               = klen_r[5:2];
                  k_wdata               = {acc_r, in_data.data_byte};
                  kval_nxt[klen_r[5:2]] = 1'b1;
                end
              end else if (klen_r == 64'd64) begin
                for (int i = 0; i < 8; i++) chain_nxt[i] = h_init(3'(i));
                pad_nxt   = 8'h00;
                job_nxt   = J_BLOCK;
                idx_nxt   = 5'd0;
                state_nxt = S_KLOAD;
              end else if (klen_r[1:0] == 2'd3) begin
                w_we    = 1'b1;
                w_waddr = klen_r[5:2];
                w_wdata = {acc_r, in_data.data_byte};
                if (klen_r[5:0] == 6'd63) begin
                  job_nxt   = J_BLOCK;
                  state_nxt = S_CSTART;
                end
              end
            end else if (in_data.action == ACT_KEY_END) begin
              if (klen_r > 64'd64) begin
                fpos_nxt    = klen_r[5:0];
                fbits_nxt   = {klen_r[60:0], 3'b000};
                fin_job_nxt = J_KEYDIG;
                state_nxt   = S_FPAD;
              end else begin
                if (klen_r[1:0] != 2'd0) begin
                  k_we                  = 1'b1;
                  k_waddr               = klen_r[5:2];
                  k_wdata               = part_word;
                  kval_nxt[klen_r[5:2]] = 1'b1;
                end
                for (int i = 0; i < 8; i++) chain_nxt[i] = h_init(3'(i));
                pad_nxt   = IPAD;
                job_nxt   = J_IPAD;
                idx_nxt   = 5'd0;
                state_nxt = S_KLOAD;
              end
            end
          end else begin
            if (in_data.action == ACT_MSG_BYTE) begin
              acc_nxt  = {acc_r[15:0], in_data.data_byte};
              mlen_nxt = mlen_r + 64'd1;
              if (mlen_r[1:0] == 2'd3) begin
                w_we    = 1'b1;
                w_waddr = mlen_r[5:2];
                w_wdata = {acc_r, in_data.data_byte};
                if (mlen_r[5:0] == 6'd63) begin
                  job_nxt   = J_BLOCK;
                  state_nxt = S_CSTART;
                end
              end
            end else if (in_data.action == ACT_MSG_END) begin
              fpos_nxt    = total[5:0];
              fbits_nxt   = {total[60:0], 3'b000};
              fin_job_nxt = J_INNER;
              state_nxt   = S_FPAD;
            end
          end
        end
      end

      S_KLOAD: begin
        if (idx_r != 5'd0) begin
          w_we    = 1'b1;
          w_waddr = kprev;
          w_wdata = (kval_r[kprev] ? k_q : 32'h0) ^ {4{pad_r}};
        end
        if (idx_r[4]) begin
          state_nxt = S_CSTART;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      S_CSTART: begin
        v_nxt     = chain_r;
        t_nxt     = 6'd0;
        pend_nxt  = 1'b0;
        w_ra      = 4'd0;
        w_rb      = 4'd1;
        state_nxt = S_R0;
      end

      S_R0: begin
        if (pend_r) begin
          v_nxt = rnd;
        end
        w16_nxt   = w_qa;
        w15_nxt   = w_qb;
        w_ra      = t_r[3:0] + 4'd9;
        w_rb      = t_r[3:0] + 4'd14;
        state_nxt = S_R1;
      end

      S_R1: begin
        w_we     = 1'b1;
        w_waddr  = t_r[3:0];
        w_wdata  = w_calc;
        w_nxt    = w_calc;
        k_nxt    = k_round(t_r);
        pend_nxt = 1'b1;
        if (t_r == 6'd63) begin
          state_nxt = S_RLAST;
        end else begin
          t_nxt     = t_r + 6'd1;
          w_ra      = t_r[3:0] + 4'd1;
          w_rb      = t_r[3:0] + 4'd2;
          state_nxt = S_R0;
        end
      end

      S_RLAST: begin
        v_nxt     = rnd;
        state_nxt = S_CADD;
      end

      S_CADD: begin
        chain_nxt = sum;
        unique case (job_r)
          J_BLOCK: state_nxt = S_IDLE;
          J_IPAD: begin
            phase_nxt = 1'b1;
            mlen_nxt  = 64'd0;
            state_nxt = S_IDLE;
          end
          J_PAD2: begin
            lenhere_nxt = 1'b1;
            idx_nxt     = 5'd0;
            state_nxt   = S_FZERO;
          end
          J_KEYDIG: begin
            idx_nxt        = 5'd0;
            kval_nxt[15:8] = 8'h00;
            state_nxt      = S_KDIG;
          end
          J_INNER: begin
            inner_nxt = sum;
            for (int i = 0; i < 8; i++) chain_nxt[i] = h_init(3'(i));
            pad_nxt   = OPAD;
            job_nxt   = J_OPAD;
            idx_nxt   = 5'd0;
            state_nxt = S_KLOAD;
          end
          J_OPAD: begin
            idx_nxt   = 5'd0;
            state_nxt = S_OLOAD;
          end
          J_TAG: begin
            ek_nxt    = 2'd0;
            state_nxt = S_EMIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_FPAD: begin
        w_we        = 1'b1;
        w_waddr     = fpos_r[5:2];
        w_wdata     = pad_word;
        idx_nxt     = {1'b0, fpos_r[5:2]} + 5'd1;
        lenhere_nxt = (fpos_r < 6'd56);
        state_nxt   = S_FZERO;
      end

      S_FZERO: begin
        if (idx_r[4]) begin
          job_nxt   = lenhere_r ? fin_job_r : J_PAD2;
          state_nxt = S_CSTART;
        end else begin
          w_we    = 1'b1;
          w_waddr = idx_r[3:0];
          if (lenhere_r && idx_r == 5'd14) begin
            w_wdata = fbits_r[63:32];
          end else if (lenhere_r && idx_r == 5'd15) begin
            w_wdata = fbits_r[31:0];
          end else begin
            w_wdata = 32'h0;
          end
          idx_nxt = idx_r + 5'd1;
        end
      end

      S_KDIG: begin
        k_we                 = 1'b1;
        k_waddr              = idx_r[3:0];
        k_wdata              = chain_r[idx_r[2:0]];
        kval_nxt[idx_r[3:0]] = 1'b1;
        if (idx_r == 5'd7) begin
          for (int i = 0; i < 8; i++) chain_nxt[i] = h_init(3'(i));
          pad_nxt   = IPAD;
          job_nxt   = J_IPAD;
          idx_nxt   = 5'd0;
          state_nxt = S_KLOAD;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      S_OLOAD: begin
        w_we    = 1'b1;
        w_waddr = idx_r[3:0];
        if (idx_r < 5'd8) begin
          w_wdata = inner_r[idx_r[2:0]];
        end else if (idx_r == 5'd8) begin
          w_wdata = 32'h8000_0000;
        end else if (idx_r == 5'd15) begin
          w_wdata = 32'd768;
        end else begin
          w_wdata = 32'h0;
        end
        if (idx_r == 5'd15) begin
          job_nxt   = J_TAG;
          state_nxt = S_CSTART;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      S_EMIT: begin
        if (!oval_r) begin
          oval_nxt  = 1'b1;
          oword_nxt = {chain_r[{ek_r, 1'b0}], chain_r[{ek_r, 1'b1}]};
          olast_nxt = (ek_r == 2'd3);
        end else if (!out_stall) begin
          oval_nxt = 1'b0;
          if (ek_r == 2'd3) begin
            klen_nxt  = 64'd0;
            mlen_nxt  = 64'd0;
            phase_nxt = 1'b0;
            kval_nxt  = 16'h0;
            for (int i = 0; i < 8; i++) chain_nxt[i] = h_init(3'(i));
            state_nxt = S_IDLE;
          end else begin
            ek_nxt = ek_r + 2'd1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      klen_r  <= '0;
      mlen_r  <= '0;
      phase_r <= 1'b0;
      kval_r  <= '0;
      oval_r  <= 1'b0;
      for (int i = 0; i < 8; i++) chain_r[i] <= h_init(3'(i));
    end else begin
      state_r <= state_nxt;
      klen_r  <= klen_nxt;
      mlen_r  <= mlen_nxt;
      phase_r <= phase_nxt;
      kval_r  <= kval_nxt;
      oval_r  <= oval_nxt;
      chain_r <= chain_nxt;
    end
    job_r     <= job_nxt;
    fin_job_r <= fin_job_nxt;
    idx_r     <= idx_nxt;
    pad_r     <= pad_nxt;
    acc_r     <= acc_nxt;
    v_r       <= v_nxt;
    inner_r   <= inner_nxt;
    t_r       <= t_nxt;
    pend_r    <= pend_nxt;
    w16_r     <= w16_nxt;
    w15_r     <= w15_nxt;
    w_r       <= w_nxt;
    k_r       <= k_nxt;
    fpos_r    <= fpos_nxt;
    fbits_r   <= fbits_nxt;
    lenhere_r <= lenhere_nxt;
    oword_r   <= oword_nxt;
    olast_r   <= olast_nxt;
    ek_r      <= ek_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = oval_r;
  assign out_data.tag_word  = oword_r;
  assign out_data.last_word = olast_r;

endmodule

[rtl/core/hse_checker.sv]
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine port checker
// Watches the engine's ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module hse_port_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input hse_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input hse_pkg::out_t out_data
);
  import hse_pkg::*;

  // A stalled result must still be offered on the next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // The tag is emitted only while the input side is held off.
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while tag words are pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_word |=> !out_valid && !in_stall)
    else $error("engine not idle after the final tag transfer");

endmodule

bind hmac_sha256_engine hse_port_checker u_hse_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[verif/hse_checker.sv]
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine checker
// Watches both channels of the engine. It keeps its own HMAC-SHA256
// calculation, fed by every accepted input transfer, and compares each
// accepted tag word with the oldest predicted word.
// ----------------------------------------------------------------------------
module hse_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  hse_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  hse_pkg::out_t out_data,
  output int            errors,
  output int            tags_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hse_pkg::*;

  typedef enum logic {LOAD_KEY, LOAD_MSG} stage_t;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [63:0] key_blk [8];
  logic [63:0] key_len;
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [31:0] sched [16];
  logic [63:0] msg_len;
  stage_t      stage;
  out_t        tag_q [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void sha_compress();
    logic [31:0] v [8];
    logic [31:0] w, a, b, s0, s1, ch, mj, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = blk[t];
      end else begin
        a = sched[(t - 15) & 15];
        b = sched[(t - 2) & 15];
        s0 = ror(a, 7) ^ ror(a, 18) ^ (a >> 3);
        s1 = ror(b, 17) ^ ror(b, 19) ^ (b >> 10);
        w = sched[t & 15] + s0 + sched[(t - 7) & 15] + s1;
      end
      sched[t & 15] = w;
      s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + RK[t] + w;
      s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function void put_byte(input int pos, input logic [7:0] b);
    blk[(pos >> 2) & 15][31 - 8 * (pos & 3) -: 8] = b;
  endfunction

  function void load_padded_key(input logic [7:0] pad);
    for (int i = 0; i < 8; i++) begin
      blk[2 * i]     = key_blk[i][63:32] ^ {4{pad}};
      blk[2 * i + 1] = key_blk[i][31:0] ^ {4{pad}};
    end
  endfunction

  function void restart_chain();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
  endfunction

  function void pad_and_close(input logic [63:0] total);
    int pos;
    logic [63:0] bits;
    pos = int'(total[5:0]);
    bits = total << 3;
    put_byte(pos, 8'h80);
    for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
    if (pos >= 56) begin
      sha_compress();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    sha_compress();
  endfunction

  function void clear_hmac();
    for (int i = 0; i < 8; i++) key_blk[i] = '0;
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
      sched[i] = '0;
    end
    restart_chain();
    key_len = '0;
    msg_len = '0;
    stage = LOAD_KEY;
  endfunction

  function void absorb(input in_t item);
    int pos;
    logic [31:0] inner [8];
    out_t tw;
    if (stage == LOAD_KEY) begin
      if (item.action == ACT_KEY_BYTE) begin
        pos = int'(key_len[5:0]);
        if (key_len < 64) begin
          key_blk[pos >> 3][63 - 8 * (pos & 7) -: 8] = item.data_byte;
        end else begin
          if (key_len == 64) begin
            restart_chain();
            load_padded_key(8'h00);
            sha_compress();
          end
          put_byte(pos, item.data_byte);
          if (pos == 63) sha_compress();
        end
        key_len = key_len + 1;
      end else if (item.action == ACT_KEY_END) begin
        if (key_len > 64) begin
          pad_and_close(key_len);
          for (int i = 0; i < 8; i++)
            key_blk[i] = (i < 4) ? {chain[2 * i], chain[2 * i + 1]} : 64'd0;
        end
        restart_chain();
        load_padded_key(IPAD);
        sha_compress();
        msg_len = '0;
        stage = LOAD_MSG;
      end
    end else if (item.action == ACT_MSG_BYTE) begin
      pos = int'(msg_len[5:0]);
      put_byte(pos, item.data_byte);
      if (pos == 63) sha_compress();
      msg_len = msg_len + 1;
    end else if (item.action == ACT_MSG_END) begin
      pad_and_close(msg_len + 64);
      for (int i = 0; i < 8; i++) inner[i] = chain[i];
      restart_chain();
      load_padded_key(OPAD);
      sha_compress();
      for (int i = 0; i < 16; i++) blk[i] = (i < 8) ? inner[i] : '0;
      blk[8] = 32'h80000000;
      blk[15] = 32'd768;
      sha_compress();
      for (int i = 0; i < 4; i++) begin
        tw.tag_word = {chain[2 * i], chain[2 * i + 1]};
        tw.last_word = (i == 3);
        tag_q.push_back(tw);
      end
      clear_hmac();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_hmac();
      tag_q.delete();
      errors <= 0;
      tags_pending <= 0;
    end else begin
      if (in_valid && !in_stall) absorb(in_data);
      if (out_valid && !out_stall) begin
        if (tag_q.size() == 0) begin
          $display("%0t: unexpected tag word: expected none, actual %h last %b",
                   $time, out_data.tag_word, out_data.last_word);
          errors <= errors + 1;
        end else begin
          if (out_data.tag_word !== tag_q[0].tag_word ||
              out_data.last_word !== tag_q[0].last_word) begin
            $display("%0t: tag word mismatch: expected %h last %b, actual %h last %b",
                     $time, tag_q[0].tag_word, tag_q[0].last_word,
                     out_data.tag_word, out_data.last_word);
            errors <= errors + 1;
          end
          void'(tag_q.pop_front());
        end
      end
      tags_pending <= tag_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine testbench
// Streams directed and random key and message sequences into the engine,
// with random idling on both channels, and lets the checker compare every
// tag word with its own HMAC-SHA256 calculation.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hse_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;
  int    errors;
  int    tags_pending;
  int    sent;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    quiet_cycles;

  hmac_sha256_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hse_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .errors       (errors),
    .tags_pending (tags_pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [1:0] act, input logic [7:0] b);
    logic taken;
    if (sent < 127) begin
      send_idle_pct = 12;
      recv_stall_pct = 78;
    end else if (sent < 254) begin
      send_idle_pct = 78;
      recv_stall_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, data_byte: b};
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic run_hmac(input int key_bytes, input int msg_bytes);
    for (int i = 0; i < key_bytes; i++) begin
      if ($urandom_range(0, 99) < 8)
        send($urandom_range(0, 1) ? ACT_MSG_BYTE : ACT_MSG_END, 8'($urandom));
      send(ACT_KEY_BYTE, 8'($urandom));
    end
    send(ACT_KEY_END, 8'($urandom));
    for (int i = 0; i < msg_bytes; i++) begin
      if ($urandom_range(0, 99) < 8)
        send($urandom_range(0, 1) ? ACT_KEY_BYTE : ACT_KEY_END, 8'($urandom));
      send(ACT_MSG_BYTE, 8'($urandom));
    end
    send(ACT_MSG_END, 8'($urandom));
  endtask

  initial begin
    int r, klen, mlen, room;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    sent = 0;
    send_idle_pct = 12;
    recv_stall_pct = 78;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_hmac(0, 0);
    send(ACT_MSG_BYTE, 8'hFF);
    send(ACT_MSG_END, 8'h00);
    send(ACT_KEY_BYTE, 8'h00);
    send(ACT_KEY_BYTE, 8'hFF);
    send(ACT_KEY_END, 8'hFF);
    send(ACT_KEY_BYTE, 8'hAA);
    send(ACT_KEY_END, 8'h55);
    send(ACT_MSG_BYTE, 8'h00);
    send(ACT_MSG_BYTE, 8'hFF);
    send(ACT_MSG_END, 8'h55);
    in_valid <= 1'b0;
    do @(negedge clk); while (tags_pending != 0);
    @(posedge clk);

    while (sent < 380) begin
      r = $urandom_range(0, 99);
      klen = (r < 60) ? $urandom_range(0, 10) :
             (r < 85) ? $urandom_range(60, 70) : $urandom_range(120, 135);
      r = $urandom_range(0, 99);
      mlen = (r < 65) ? $urandom_range(0, 12) :
             (r < 90) ? $urandom_range(52, 70) : $urandom_range(110, 130);
      room = (sent < 378) ? 378 - sent : 0;
      if (klen > room) klen = room;
      if (mlen > room - klen) mlen = room - klen;
      run_hmac(klen, mlen);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (tags_pending != 0);
    @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0 && tags_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
